// File: hdl/sccpu_pkg.sv
// shared constants, types and alu function of the 16-bit single-cycle cpu
package sccpu_pkg;

	localparam int DATA_W        = 16;
	localparam int OP_W          = 4;
	localparam int FIELD_W       = 3;
	localparam int IMM_W         = 9;
	localparam int REG_COUNT_DEF = 8;

	localparam int OP_LSB   = 12;
	localparam int DEST_LSB = 9;
	localparam int SRCA_LSB = 6;
	localparam int SRCB_LSB = 3;

	localparam logic [OP_W-1:0] OP_LDI = 4'd8;
	localparam logic [OP_W-1:0] OP_LDR = 4'd9;
	localparam logic [OP_W-1:0] OP_STR = 4'd10;
	localparam logic [OP_W-1:0] OP_JMP = 4'd11;
	localparam logic [OP_W-1:0] OP_JEQ = 4'd12;

	localparam logic [2:0] ALU_ADD = 3'd0;
	localparam logic [2:0] ALU_SUB = 3'd1;
	localparam logic [2:0] ALU_AND = 3'd2;
	localparam logic [2:0] ALU_OR  = 3'd3;
	localparam logic [2:0] ALU_XOR = 3'd4;
	localparam logic [2:0] ALU_NOT = 3'd5;
	localparam logic [2:0] ALU_SHL = 3'd6;
	localparam logic [2:0] ALU_SHR = 3'd7;

	typedef struct packed {
		logic               we;
		logic [FIELD_W-1:0] dest;
		logic [DATA_W-1:0]  data;
	} sccpu_wb_t;

	function automatic logic [DATA_W-1:0] alu_eval(input logic [2:0] op,
		input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] r;
		case (op)
			ALU_ADD: r = a + b;
			ALU_SUB: r = a - b;
			ALU_AND: r = a & b;
			ALU_OR:  r = a | b;
			ALU_XOR: r = a ^ b;
			ALU_NOT: r = ~a;
			ALU_SHL: r = {a[DATA_W-2:0], 1'b0};
			ALU_SHR: r = {1'b0, a[DATA_W-1:1]};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/sccpu_regfile.sv
// register file: synchronous two-read one-write memory with reset valid bits and bypass
module sccpu_regfile
	import sccpu_pkg::*;
#(
	parameter int REG_COUNT = REG_COUNT_DEF,
	localparam int AW = $clog2(REG_COUNT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr_a,
	input  logic [AW-1:0]     rd_addr_b,
	input  sccpu_wb_t         wb,
	output logic [DATA_W-1:0] rd_data_a,
	output logic [DATA_W-1:0] rd_data_b
);

	logic [DATA_W-1:0] mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [AW-1:0] wr_addr;

	logic [DATA_W-1:0] ram_a_s1, ram_b_s1, fwd_data_s1;
	logic vld_a_s1, vld_b_s1, fwd_a_s1, fwd_b_s1;

	assign wr_addr = wb.dest[AW-1:0];

	always_ff @(posedge clk) begin
		if (wb.we) begin
			mem[wr_addr] <= wb.data;
		end
		if (rd_en) begin
			ram_a_s1    <= mem[rd_addr_a];
			ram_b_s1    <= mem[rd_addr_b];
			fwd_data_s1 <= wb.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_a_s1 <= 1'b0;
			vld_b_s1 <= 1'b0;
			fwd_a_s1 <= 1'b0;
			fwd_b_s1 <= 1'b0;
		end else begin
			if (wb.we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_s1 <= vld_q[rd_addr_a];
				vld_b_s1 <= vld_q[rd_addr_b];
				// write landing at the same edge as the read
				fwd_a_s1 <= wb.we && (wr_addr == rd_addr_a);
				fwd_b_s1 <= wb.we && (wr_addr == rd_addr_b);
			end
		end
	end

	assign rd_data_a = fwd_a_s1 ? fwd_data_s1 : (vld_a_s1 ? ram_a_s1 : '0);
	assign rd_data_b = fwd_b_s1 ? fwd_data_s1 : (vld_b_s1 ? ram_b_s1 : '0);

endmodule

// File: hdl/sccpu_exec.sv
// execute stage: decode, alu, write-back selection and next pc
module sccpu_exec
	import sccpu_pkg::*;
(
	input  logic [DATA_W-1:0] instr,
	input  logic [DATA_W-1:0] mem_data,
	input  logic              rst_pc,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	input  logic [DATA_W-1:0] pc,
	input  logic              zero,
	output sccpu_wb_t         wb,
	output logic [DATA_W-1:0] pc_next,
	output logic              zero_next,
	output logic              is_str
);

	logic [OP_W-1:0]   opcode;
	logic [DATA_W-1:0] imm, alu_b, alu_out;
	logic is_ldi, is_ldr, jump;

	assign opcode = instr[OP_LSB +: OP_W];
	assign imm    = {{(DATA_W-IMM_W){1'b0}}, instr[IMM_W-1:0]};
	assign is_ldi = opcode == OP_LDI;
	assign is_ldr = opcode == OP_LDR;
	assign is_str = opcode == OP_STR;
	assign alu_b  = is_ldi ? imm : b;

	assign alu_out   = alu_eval(opcode[2:0], a, alu_b);
	assign zero_next = alu_out == '0;

	always_comb begin
		wb.we   = !opcode[OP_W-1] || is_ldi || is_ldr;
		wb.dest = instr[DEST_LSB +: FIELD_W];
		wb.data = is_ldi ? imm : (is_ldr ? mem_data : alu_out);
	end

	assign jump = (opcode == OP_JMP) || ((opcode == OP_JEQ) && zero);

	always_comb begin
		if (rst_pc) begin
			pc_next = '0;
		end else if (jump) begin
			pc_next = a;
		end else begin
			pc_next = pc + DATA_W'(1);
		end
	end

endmodule

// File: hdl/single_cycle_cpu_16bit.sv
// top level of the 16-bit single-cycle cpu: handshake, pipeline and architectural state
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------------
//  input    | in_valid / in_ready        | instruction, mem_read_data, reset_pc
//  output   | out_valid / out_ready      | next_pc, mem_write_enable, mem_address,
//           |                            | mem_write_data
//
// one item per cycle sustained while the output is not stalled; an item's result is registered
// first at the register file read edge, then after execute and write back into the output register
// the register file read overlaps the previous item's write back, bypassed in the regfile
// reset clears pc, zero flag, pipeline valids and the register file valid bits at once
// a stalled output holds the execute stage, which then holds the input side
module single_cycle_cpu_16bit
	import sccpu_pkg::*;
#(
	parameter int REG_COUNT = REG_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] instruction,
	input  logic [DATA_W-1:0] mem_read_data,
	input  logic              reset_pc,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] next_pc,
	output logic              mem_write_enable,
	output logic [DATA_W-1:0] mem_address,
	output logic [DATA_W-1:0] mem_write_data
);

	localparam int AW = $clog2(REG_COUNT);

	logic accept, advance;
	logic vld_s1, out_vld_q;
	logic [DATA_W-1:0] instr_s1, mrd_s1;
	logic rpc_s1;

	logic [DATA_W-1:0] pc_q;
	logic zero_q;

	logic [DATA_W-1:0] reg_a, reg_b, pc_next;
	logic zero_next, is_str;
	sccpu_wb_t wb, wb_gated;

	logic [DATA_W-1:0] next_pc_q, mem_address_q, mem_write_data_q;
	logic mem_we_q;

	assign advance  = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_comb begin
		wb_gated    = wb;
		wb_gated.we = wb.we && advance;
	end

	sccpu_regfile #(
		.REG_COUNT(REG_COUNT)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (instruction[SRCA_LSB +: AW]),
		.rd_addr_b (instruction[SRCB_LSB +: AW]),
		.wb        (wb_gated),
		.rd_data_a (reg_a),
		.rd_data_b (reg_b)
	);

	sccpu_exec u_exec (
		.instr     (instr_s1),
		.mem_data  (mrd_s1),
		.rst_pc    (rpc_s1),
		.a         (reg_a),
		.b         (reg_b),
		.pc        (pc_q),
		.zero      (zero_q),
		.wb        (wb),
		.pc_next   (pc_next),
		.zero_next (zero_next),
		.is_str    (is_str)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instruction;
			mrd_s1   <= mem_read_data;
			rpc_s1   <= reset_pc;
		end
		if (advance) begin
			next_pc_q        <= pc_next;
			mem_we_q         <= is_str;
			mem_address_q    <= reg_a;
			mem_write_data_q <= reg_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			pc_q      <= '0;
			zero_q    <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				out_vld_q <= 1'b1;
				pc_q      <= pc_next;
				zero_q    <= zero_next;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_vld_q;
	assign next_pc          = next_pc_q;
	assign mem_write_enable = mem_we_q;
	assign mem_address      = mem_address_q;
	assign mem_write_data   = mem_write_data_q;

endmodule
